### hw/rtl/ising_pkg.sv
`timescale 1ns / 1ps
// shared widths, register codes and defaults for the ising spin update block
// no dependencies; used by the channel interfaces and the top level

package ising_pkg;

    localparam int SITE_W   = 5;
    localparam int FRAC_W   = 32;
    localparam int DH_W     = 5;
    localparam int ENERGY_W = 13;
    localparam int MAG_W    = 12;

    localparam int DEFAULT_LATTICE_SIDE = 32;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr bit 2
    localparam logic REG_ACCEPT_DH4 = 1'b0;
    localparam logic REG_ACCEPT_DH8 = 1'b1;

    // most recent lattice change, used for read forwarding
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_WRITE = 2'd1;
    localparam logic [1:0] EV_CLEAR = 2'd2;

    localparam logic MODE_TRIAL    = 1'b0;
    localparam logic MODE_ALL_UP   = 1'b1;

endpackage

### hw/rtl/ising_trial_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one trial item into the block
// depends on ising_pkg for field widths

interface ising_trial_if
    import ising_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SITE_W-1:0] site_row;
    logic [SITE_W-1:0] site_col;
    logic [FRAC_W-1:0] random_fraction;

    modport source (
        output valid, mode, site_row, site_col, random_fraction,
        input  ready
    );

    modport sink (
        input  valid, mode, site_row, site_col, random_fraction,
        output ready
    );
endinterface

### hw/rtl/ising_result_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one result item out of the block
// depends on ising_pkg for field widths

interface ising_result_if
    import ising_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       flipped;
    logic                       bad_site;
    logic signed [DH_W-1:0]     energy_change;
    logic signed [ENERGY_W-1:0] total_energy;
    logic signed [MAG_W-1:0]    total_magnetization;

    modport source (
        output valid, flipped, bad_site, energy_change, total_energy, total_magnetization,
        input  ready
    );

    modport sink (
        input  valid, flipped, bad_site, energy_change, total_energy, total_magnetization,
        output ready
    );
endinterface

### hw/rtl/ising_metropolis_spin_update_top.sv
`timescale 1ns / 1ps
// Metropolis single-spin update on a periodic square Ising lattice
// depends on ising_pkg, ising_trial_if and ising_result_if
//
// Usage:
//   trial  : valid/ready input channel; mode 0 runs a Metropolis trial at
//            (site_row, site_col) with random_fraction, mode 1 sets every
//            spin up and restores the energy and magnetization totals
//   result : valid/ready output channel, one item per trial item, with the
//            flip flag, bad-site flag, applied energy change and new totals
//   apb    : accept_below_dh4 at byte 0x0, accept_below_dh8 at byte 0x4;
//            write only while the block is idle, pready is always high
// Pipeline: the accepting edge loads the working stage; when the item advances,
//   it loads the result register, from which the result is taken.
// Throughput: one item per cycle while the result is taken; the lattice is kept as rows in three
//   replicated row memories (previous, own and next row read together) and
//   the row written by the item just before is forwarded.
// Reset: every spin up, totals at -2*side^2 and side^2, thresholds zero;
//   the block is ready right away (per-row valid bits, no clearing pass).
// Stall: while the result register is held, one more item is accepted and
//   parked in the working stage; then ready drops until the result is taken.

module ising_metropolis_spin_update_top
    import ising_pkg::*;
#(
    parameter int LATTICE_SIDE = DEFAULT_LATTICE_SIDE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ising_trial_if.sink           trial,
    ising_result_if.source        result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int EXT_W  = ((SITE_W > ADDR_W) ? SITE_W : ADDR_W) + 1;
    localparam int SITES  = LATTICE_SIDE * LATTICE_SIDE;

    localparam logic [EXT_W-1:0] SIDE_EXT = EXT_W'(LATTICE_SIDE);
    localparam logic [EXT_W-1:0] LAST_EXT = EXT_W'(LATTICE_SIDE - 1);
    localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
    localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);
    localparam logic signed [MAG_W-1:0]    MAG_STEP     = MAG_W'(2);
    localparam logic [LATTICE_SIDE-1:0]    ROW_ALL_UP   = '1;

    // ---------------- configuration ----------------
    logic [FRAC_W-1:0] accept_dh4_reg;
    logic [FRAC_W-1:0] accept_dh8_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ACCEPT_DH8) ? accept_dh8_reg : accept_dh4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_dh4_reg <= '0;
            accept_dh8_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ACCEPT_DH4: accept_dh4_reg <= pwdata;
                REG_ACCEPT_DH8: accept_dh8_reg <= pwdata;
                default:        accept_dh4_reg <= accept_dh4_reg;
            endcase
        end
    end

    // ---------------- input side: address generation ----------------
    logic             accept_in;
    logic             advance;
    logic [EXT_W-1:0] in_row_ext;
    logic [EXT_W-1:0] in_col_ext;
    logic             in_bad;
    logic [ADDR_W-1:0] in_ctr_addr;
    logic [ADDR_W-1:0] in_up_addr;
    logic [ADDR_W-1:0] in_dn_addr;

    assign in_row_ext  = EXT_W'(trial.site_row);
    assign in_col_ext  = EXT_W'(trial.site_col);
    assign in_bad      = (in_row_ext >= SIDE_EXT) || (in_col_ext >= SIDE_EXT);
    assign in_ctr_addr = in_row_ext[ADDR_W-1:0];

    always_comb
    begin
        logic [EXT_W-1:0] up_ext;
        logic [EXT_W-1:0] dn_ext;
        up_ext = (in_row_ext == '0) ? LAST_EXT : (in_row_ext - EXT_W'(1));
        dn_ext = (in_row_ext == LAST_EXT) ? '0 : (in_row_ext + EXT_W'(1));
        in_up_addr = up_ext[ADDR_W-1:0];
        in_dn_addr = dn_ext[ADDR_W-1:0];
    end

    // ---------------- working stage ----------------
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_mode_reg;
    logic                    s1_bad_reg;
    logic [ADDR_W-1:0]       s1_ctr_addr_reg;
    logic [ADDR_W-1:0]       s1_up_addr_reg;
    logic [ADDR_W-1:0]       s1_dn_addr_reg;
    logic [ADDR_W-1:0]       s1_col_reg;
    logic [FRAC_W-1:0]       s1_frac_reg;
    logic [LATTICE_SIDE-1:0] s1_up_row_reg;
    logic [LATTICE_SIDE-1:0] s1_ctr_row_reg;
    logic [LATTICE_SIDE-1:0] s1_dn_row_reg;
    logic                    s1_up_vld_reg;
    logic                    s1_ctr_vld_reg;
    logic                    s1_dn_vld_reg;

    // row memories: three copies so three rows can be read together
    logic [LATTICE_SIDE-1:0] mem_up  [LATTICE_SIDE];
    logic [LATTICE_SIDE-1:0] mem_ctr [LATTICE_SIDE];
    logic [LATTICE_SIDE-1:0] mem_dn  [LATTICE_SIDE];
    logic [LATTICE_SIDE-1:0] row_valid_reg;

    logic                    row_wr;
    logic [LATTICE_SIDE-1:0] row_wr_data;
    logic                    lattice_clear;

    logic [1:0]              ev_kind_reg;
    logic [ADDR_W-1:0]       ev_addr_reg;
    logic [LATTICE_SIDE-1:0] ev_data_reg;

    assign trial.ready = !s1_valid_reg || advance;
    assign accept_in   = trial.valid && trial.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_in)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (row_wr)
        begin
            mem_up[s1_ctr_addr_reg]  <= row_wr_data;
            mem_ctr[s1_ctr_addr_reg] <= row_wr_data;
            mem_dn[s1_ctr_addr_reg]  <= row_wr_data;
        end
        if (accept_in)
        begin
            s1_mode_reg     <= trial.mode;
            s1_bad_reg      <= in_bad;
            s1_ctr_addr_reg <= in_ctr_addr;
            s1_up_addr_reg  <= in_up_addr;
            s1_dn_addr_reg  <= in_dn_addr;
            s1_col_reg      <= in_col_ext[ADDR_W-1:0];
            s1_frac_reg     <= trial.random_fraction;
            s1_up_row_reg   <= mem_up[in_up_addr];
            s1_ctr_row_reg  <= mem_ctr[in_ctr_addr];
            s1_dn_row_reg   <= mem_dn[in_dn_addr];
            s1_up_vld_reg   <= row_valid_reg[in_up_addr];
            s1_ctr_vld_reg  <= row_valid_reg[in_ctr_addr];
            s1_dn_vld_reg   <= row_valid_reg[in_dn_addr];
        end
    end

    // effective rows: an unwritten row reads all up; the last change is forwarded
    logic [LATTICE_SIDE-1:0] up_row;
    logic [LATTICE_SIDE-1:0] ctr_row;
    logic [LATTICE_SIDE-1:0] dn_row;

    always_comb
    begin
        up_row  = s1_up_vld_reg  ? s1_up_row_reg  : ROW_ALL_UP;
        ctr_row = s1_ctr_vld_reg ? s1_ctr_row_reg : ROW_ALL_UP;
        dn_row  = s1_dn_vld_reg  ? s1_dn_row_reg  : ROW_ALL_UP;
        case (ev_kind_reg)
            EV_CLEAR:
            begin
                up_row  = ROW_ALL_UP;
                ctr_row = ROW_ALL_UP;
                dn_row  = ROW_ALL_UP;
            end
            EV_WRITE:
            begin
                if (ev_addr_reg == s1_up_addr_reg)
                    up_row = ev_data_reg;
                if (ev_addr_reg == s1_ctr_addr_reg)
                    ctr_row = ev_data_reg;
                if (ev_addr_reg == s1_dn_addr_reg)
                    dn_row = ev_data_reg;
            end
            default:
            begin
                up_row = up_row;
            end
        endcase
    end

    // neighbor count and acceptance
    logic [ADDR_W-1:0]      col_left;
    logic [ADDR_W-1:0]      col_right;
    logic                   spin;
    logic [2:0]             matches_cnt;
    logic signed [DH_W-1:0] dh;
    logic                   take_flip;
    logic                   do_flip;

    always_comb
    begin
        logic [EXT_W-1:0] col_ext;
        logic [EXT_W-1:0] left_ext;
        logic [EXT_W-1:0] right_ext;
        col_ext   = EXT_W'(s1_col_reg);
        left_ext  = (col_ext == '0) ? LAST_EXT : (col_ext - EXT_W'(1));
        right_ext = (col_ext == LAST_EXT) ? '0 : (col_ext + EXT_W'(1));
        col_left  = left_ext[ADDR_W-1:0];
        col_right = right_ext[ADDR_W-1:0];
    end

    assign spin = ctr_row[s1_col_reg];

    // dH = 4*(neighbors equal to the spin) - 8
    assign matches_cnt = 3'(up_row[s1_col_reg] == spin) + 3'(dn_row[s1_col_reg] == spin)
                       + 3'(ctr_row[col_left] == spin) + 3'(ctr_row[col_right] == spin);

    always_comb
    begin
        case (matches_cnt)
            3'd0:
            begin
                dh        = -DH_W'(8);
                take_flip = 1'b1;
            end
            3'd1:
            begin
                dh        = -DH_W'(4);
                take_flip = 1'b1;
            end
            3'd2:
            begin
                dh        = '0;
                take_flip = 1'b1;
            end
            3'd3:
            begin
                dh        = DH_W'(4);
                take_flip = s1_frac_reg < accept_dh4_reg;
            end
            default:
            begin
                dh        = DH_W'(8);
                take_flip = s1_frac_reg < accept_dh8_reg;
            end
        endcase
    end

    assign do_flip       = (s1_mode_reg == MODE_TRIAL) && !s1_bad_reg && take_flip;
    assign row_wr        = advance && do_flip;
    assign row_wr_data   = ctr_row ^ (LATTICE_SIDE'(1) << s1_col_reg);
    assign lattice_clear = advance && (s1_mode_reg == MODE_ALL_UP);

    // ---------------- totals ----------------
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;
    logic signed [MAG_W-1:0]    mag_reg;
    logic signed [MAG_W-1:0]    mag_next;

    always_comb
    begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        if (s1_mode_reg == MODE_ALL_UP)
        begin
            energy_next = ENERGY_RESET;
            mag_next    = MAG_RESET;
        end
        else if (do_flip)
        begin
            energy_next = energy_reg + ENERGY_W'(dh);
            mag_next    = spin ? (mag_reg - MAG_STEP) : (mag_reg + MAG_STEP);
        end
    end

    // ---------------- result register ----------------
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   res_flipped_reg;
    logic                   res_bad_reg;
    logic signed [DH_W-1:0] res_dh_reg;

    assign advance = s1_valid_reg && (!res_valid_reg || result.ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_flipped_reg <= do_flip;
            res_bad_reg     <= (s1_mode_reg == MODE_TRIAL) && s1_bad_reg;
            res_dh_reg      <= do_flip ? dh : '0;
        end
    end

    assign result.valid               = res_valid_reg;
    assign result.flipped             = res_flipped_reg;
    assign result.bad_site            = res_bad_reg;
    assign result.energy_change       = res_dh_reg;
    assign result.total_energy        = energy_reg;
    assign result.total_magnetization = mag_reg;

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            energy_reg    <= ENERGY_RESET;
            mag_reg       <= MAG_RESET;
            row_valid_reg <= '0;
            ev_kind_reg   <= EV_NONE;
            ev_addr_reg   <= '0;
            ev_data_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                energy_reg <= energy_next;
                mag_reg    <= mag_next;
            end
            if (lattice_clear)
            begin
                row_valid_reg <= '0;
                ev_kind_reg   <= EV_CLEAR;
            end
            else if (row_wr)
            begin
                row_valid_reg[s1_ctr_addr_reg] <= 1'b1;
                ev_kind_reg <= EV_WRITE;
                ev_addr_reg <= s1_ctr_addr_reg;
                ev_data_reg <= row_wr_data;
            end
        end
    end

endmodule
